/* rtl/dttp_pkg.sv */
package dttp_pkg;

  localparam int CharW  = 8;
  localparam int YearW  = 14;
  localparam int TwoW   = 7;
  localparam int MilliW = 10;
  localparam int PhaseW = 4;
  localparam int CountW = 3;

  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_CR    = 8'h0D;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_COMMA = 8'h2C;
  localparam logic [CharW-1:0] CH_DASH  = 8'h2D;
  localparam logic [CharW-1:0] CH_DOT   = 8'h2E;
  localparam logic [CharW-1:0] CH_SLASH = 8'h2F;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;
  localparam logic [CharW-1:0] CH_COLON = 8'h3A;
  localparam logic [CharW-1:0] CH_T     = 8'h54;

  localparam logic [PhaseW-1:0] PH_LEAD  = 4'd0;
  localparam logic [PhaseW-1:0] PH_YEAR  = 4'd1;
  localparam logic [PhaseW-1:0] PH_MONTH = 4'd2;
  localparam logic [PhaseW-1:0] PH_DAY   = 4'd3;
  localparam logic [PhaseW-1:0] PH_TLEAD = 4'd4;
  localparam logic [PhaseW-1:0] PH_HOUR  = 4'd5;
  localparam logic [PhaseW-1:0] PH_MIN   = 4'd6;
  localparam logic [PhaseW-1:0] PH_SEC   = 4'd7;
  localparam logic [PhaseW-1:0] PH_MS    = 4'd8;
  localparam logic [PhaseW-1:0] PH_OK    = 4'd9;
  localparam logic [PhaseW-1:0] PH_FAIL  = 4'd10;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [TwoW-1:0]   month;
    logic [TwoW-1:0]   day;
    logic [TwoW-1:0]   hour;
    logic [TwoW-1:0]   minute;
    logic [TwoW-1:0]   second;
    logic [MilliW-1:0] milli;
  } fields_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [CountW-1:0] dcnt;
    logic              sep;
    fields_t           acc;
  } parse_state_t;

  typedef struct packed {
    logic    parse_ok;
    fields_t fields;
  } result_t;

  function automatic logic is_ws(logic [CharW-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_dig(logic [CharW-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [YearW-1:0] mac10(logic [YearW-1:0] a, logic [3:0] d);
    return (a << 3) + (a << 1) + YearW'(d);
  endfunction

endpackage

/* rtl/dttp_if.sv */
interface dttp_in_if;
  import dttp_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface dttp_out_if;
  import dttp_pkg::*;

  logic              valid;
  logic              ready;
  logic              parse_ok;
  logic [YearW-1:0]  year_value;
  logic [TwoW-1:0]   month_value;
  logic [TwoW-1:0]   day_value;
  logic [TwoW-1:0]   hour_value;
  logic [TwoW-1:0]   minute_value;
  logic [TwoW-1:0]   second_value;
  logic [MilliW-1:0] milli_value;

  modport source (output valid, output parse_ok, output year_value, output month_value,
                  output day_value, output hour_value, output minute_value,
                  output second_value, output milli_value, input ready);
  modport sink   (input valid, input parse_ok, input year_value, input month_value,
                  input day_value, input hour_value, input minute_value,
                  input second_value, input milli_value, output ready);
endinterface

/* rtl/dttp_step.sv */
module dttp_step (
  input  dttp_pkg::parse_state_t        st_i,
  input  dttp_pkg::fields_t             cmt_i,
  input  logic [dttp_pkg::CharW-1:0]    char_i,
  output dttp_pkg::parse_state_t        st_o,
  output dttp_pkg::fields_t             cmt_o,
  output dttp_pkg::result_t             res_o
);
  import dttp_pkg::*;

  logic [PhaseW-1:0] ph;
  logic              skip;
  logic              ws;
  logic              dig;
  logic              endc;
  logic [3:0]        d;
  logic              do_commit;
  logic              with_time;
  logic              sep_hit;
  parse_state_t      st_n;
  fields_t           cmt_n;

  always_comb begin
    ph        = st_i.phase;
    skip      = 1'b0;
    ws        = is_ws(char_i);
    dig       = is_dig(char_i);
    endc      = ws || (char_i == CH_NUL);
    d         = char_i[3:0];
    do_commit = 1'b0;
    with_time = 1'b0;
    sep_hit   = st_i.sep ? (char_i == CH_SLASH) : (char_i == CH_DASH);
    st_n      = st_i;
    cmt_n     = cmt_i;

    if (ph == PH_LEAD) begin
      if (ws) skip = 1'b1;
      else ph = PH_YEAR;
    end
    if (ph == PH_TLEAD) begin
      if (ws) skip = 1'b1;
      else ph = PH_HOUR;
    end

    if (!skip) begin
      st_n.phase = ph;
      case (ph)
        PH_YEAR: begin
          if (dig && st_i.dcnt < 3'd4) begin
            st_n.acc.year = mac10(st_i.acc.year, d);
            st_n.dcnt     = st_i.dcnt + 3'd1;
          end else if (char_i == CH_DASH || char_i == CH_SLASH) begin
            st_n.sep   = (char_i == CH_SLASH);
            st_n.dcnt  = '0;
            st_n.phase = PH_MONTH;
          end else begin
            st_n.phase = PH_FAIL;
          end
        end
        PH_MONTH: begin
          if (dig && st_i.dcnt < 3'd2) begin
            st_n.acc.month = TwoW'(mac10(YearW'(st_i.acc.month), d));
            st_n.dcnt      = st_i.dcnt + 3'd1;
          end else if (st_i.dcnt != '0 && sep_hit) begin
            st_n.dcnt  = '0;
            st_n.phase = PH_DAY;
          end else begin
            st_n.phase = PH_FAIL;
          end
        end
        PH_DAY: begin
          if (dig && st_i.dcnt < 3'd2) begin
            st_n.acc.day = TwoW'(mac10(YearW'(st_i.acc.day), d));
            st_n.dcnt    = st_i.dcnt + 3'd1;
          end else if (st_i.dcnt == '0) begin
            st_n.phase = PH_FAIL;
          end else if (ws || char_i == CH_T) begin
            st_n.dcnt  = '0;
            st_n.phase = PH_TLEAD;
          end else begin
            do_commit = 1'b1;
          end
        end
        PH_HOUR: begin
          if (dig && st_i.dcnt < 3'd2) begin
            st_n.acc.hour = TwoW'(mac10(YearW'(st_i.acc.hour), d));
            st_n.dcnt     = st_i.dcnt + 3'd1;
          end else if (st_i.dcnt != '0 && char_i == CH_COLON) begin
            st_n.dcnt  = '0;
            st_n.phase = PH_MIN;
          end else begin
            st_n.phase = PH_FAIL;
          end
        end
        PH_MIN: begin
          if (dig && st_i.dcnt < 3'd2) begin
            st_n.acc.minute = TwoW'(mac10(YearW'(st_i.acc.minute), d));
            st_n.dcnt       = st_i.dcnt + 3'd1;
          end else if (st_i.dcnt == '0) begin
            st_n.phase = PH_FAIL;
          end else if (char_i == CH_COLON) begin
            st_n.dcnt  = '0;
            st_n.phase = PH_SEC;
          end else if (endc) begin
            do_commit = 1'b1;
            with_time = 1'b1;
          end else begin
            st_n.phase = PH_FAIL;
          end
        end
        PH_SEC: begin
          if (dig && st_i.dcnt < 3'd2) begin
            st_n.acc.second = TwoW'(mac10(YearW'(st_i.acc.second), d));
            st_n.dcnt       = st_i.dcnt + 3'd1;
          end else if (st_i.dcnt == '0) begin
            st_n.phase = PH_FAIL;
          end else if (char_i == CH_DOT || char_i == CH_COMMA) begin
            st_n.dcnt  = '0;
            st_n.phase = PH_MS;
          end else if (endc) begin
            do_commit = 1'b1;
            with_time = 1'b1;
          end else begin
            st_n.phase = PH_FAIL;
          end
        end
        PH_MS: begin
          if (dig && st_i.dcnt < 3'd3) begin
            st_n.acc.milli = MilliW'(mac10(YearW'(st_i.acc.milli), d));
            st_n.dcnt      = st_i.dcnt + 3'd1;
          end else if (st_i.dcnt == '0) begin
            st_n.phase = PH_FAIL;
          end else begin
            if (st_i.dcnt == 3'd1) begin
              st_n.acc.milli = (st_i.acc.milli << 6) + (st_i.acc.milli << 5)
                             + (st_i.acc.milli << 2);
            end else if (st_i.dcnt == 3'd2) begin
              st_n.acc.milli = (st_i.acc.milli << 3) + (st_i.acc.milli << 1);
            end
            if (endc) begin
              do_commit = 1'b1;
              with_time = 1'b1;
            end else begin
              st_n.phase = PH_FAIL;
            end
          end
        end
        PH_OK: begin
          st_n.phase = PH_OK;
        end
        default: begin
          st_n.phase = PH_FAIL;
        end
      endcase
    end

    if (do_commit) begin
      cmt_n.year   = st_n.acc.year;
      cmt_n.month  = st_n.acc.month;
      cmt_n.day    = st_n.acc.day;
      cmt_n.hour   = with_time ? st_n.acc.hour   : '0;
      cmt_n.minute = with_time ? st_n.acc.minute : '0;
      cmt_n.second = with_time ? st_n.acc.second : '0;
      cmt_n.milli  = with_time ? st_n.acc.milli  : '0;
      st_n.phase   = PH_OK;
    end

    res_o.parse_ok = (st_n.phase == PH_OK);
    res_o.fields   = cmt_n;

    if (char_i == CH_NUL) begin
      st_n       = '0;
      st_n.phase = PH_LEAD;
    end

    st_o  = st_n;
    cmt_o = cmt_n;
  end

endmodule

/* rtl/date_time_text_parser.sv */
// Date/time text parser.
// in_chan carries one character byte per transfer (valid/ready); a zero byte
// ends the string. For every zero byte one result goes out on out_chan: a
// parse_ok flag and the committed year, month, day, hour, minute, second and
// millisecond values. A string that fails leaves the committed values as they
// were and reports parse_ok low; nonzero bytes produce no result.
// Each character lands in an input register; then one pass of parse logic
// updates the state and, for a zero byte, loads the result register, and
// out_chan.valid rises with that load. Throughput is one character per cycle,
// save while a zero byte waits on a pending result; the parse state is a
// single register stage updated per character, which sets that rate.
// While a result waits for out_chan.ready, characters keep flowing until a
// second zero byte reaches the input register; that byte then holds there
// and in_chan.ready drops until the pending result transfers.
// Reset (rst_n low, synchronous) empties both registers, returns the parser
// to skipping leading whitespace and clears the committed values to zero.
module date_time_text_parser (
  input  logic         clk,
  input  logic         rst_n,
  dttp_in_if.sink      in_chan,
  dttp_out_if.source   out_chan
);
  import dttp_pkg::*;

  logic             in_vld_r;
  logic [CharW-1:0] char_r;
  logic             out_vld_r;
  result_t          res_r;
  parse_state_t     st_r;
  fields_t          cmt_r;

  parse_state_t     st_nxt;
  fields_t          cmt_nxt;
  result_t          res_nxt;
  logic             is_nul;
  logic             adv;

  assign is_nul        = (char_r == CH_NUL);
  assign adv           = in_vld_r && (!is_nul || !out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || adv;

  dttp_step u_step (
    .st_i   (st_r),
    .cmt_i  (cmt_r),
    .char_i (char_r),
    .st_o   (st_nxt),
    .cmt_o  (cmt_nxt),
    .res_o  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      char_r <= in_chan.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= {PH_LEAD, {($bits(parse_state_t) - PhaseW){1'b0}}};
      cmt_r <= '0;
    end else if (adv) begin
      st_r  <= st_nxt;
      cmt_r <= cmt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && is_nul) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && is_nul) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.parse_ok     = res_r.parse_ok;
  assign out_chan.year_value   = res_r.fields.year;
  assign out_chan.month_value  = res_r.fields.month;
  assign out_chan.day_value    = res_r.fields.day;
  assign out_chan.hour_value   = res_r.fields.hour;
  assign out_chan.minute_value = res_r.fields.minute;
  assign out_chan.second_value = res_r.fields.second;
  assign out_chan.milli_value  = res_r.fields.milli;

`ifndef SYNTHESIS
  a_nul_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && is_nul |=> st_r.phase == PH_LEAD && st_r.dcnt == '0)
    else $error("parser not restarted after end of string");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(adv) && $past(is_nul))
    else $error("result without terminating character");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_chan.ready |=> out_vld_r && $stable(res_r))
    else $error("stalled result changed or dropped");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.dcnt <= 3'd4)
    else $error("digit count out of range");
`endif

endmodule

/* tb/dttp_result_checker.sv */
`timescale 1ns / 1ps

module dttp_result_checker (
  input  logic clk,
  input  logic rst_n,
  dttp_in_if   in_mon,
  dttp_out_if  out_mon,
  output int   mismatches,
  output int   waiting,
  output int   checked
);
  import dttp_pkg::*;

  logic [PhaseW-1:0] ps_phase;
  int unsigned       ps_count;
  bit                ps_slash;
  fields_t           ps_acc;
  fields_t           held;
  result_t           expected_results[$];

  function automatic bit blank_char(logic [CharW-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit digit_char(logic [CharW-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic void clear_parse();
    ps_phase = PH_LEAD;
    ps_count = 0;
    ps_slash = 1'b0;
    ps_acc   = '0;
  endfunction

  function automatic void commit_fields(bit with_time);
    held.year  = ps_acc.year;
    held.month = ps_acc.month;
    held.day   = ps_acc.day;
    if (with_time) begin
      held.hour   = ps_acc.hour;
      held.minute = ps_acc.minute;
      held.second = ps_acc.second;
      held.milli  = ps_acc.milli;
    end else begin
      held.hour   = '0;
      held.minute = '0;
      held.second = '0;
      held.milli  = '0;
    end
    ps_phase = PH_OK;
  endfunction

  function automatic void close_time(logic [CharW-1:0] c);
    if (blank_char(c) || c == CH_NUL) commit_fields(1'b1);
    else ps_phase = PH_FAIL;
  endfunction

  function automatic void parse_char(logic [CharW-1:0] c);
    logic [3:0] d;
    bit         dg;
    d  = c[3:0];
    dg = digit_char(c);
    if (ps_phase == PH_LEAD) begin
      if (blank_char(c)) return;
      ps_phase = PH_YEAR;
    end
    if (ps_phase == PH_TLEAD) begin
      if (blank_char(c)) return;
      ps_phase = PH_HOUR;
    end
    case (ps_phase)
      PH_YEAR: begin
        if (dg && ps_count < 4) begin
          ps_acc.year = YearW'(ps_acc.year * 10 + YearW'(d));
          ps_count++;
        end else if (c == CH_DASH || c == CH_SLASH) begin
          ps_slash = (c == CH_SLASH);
          ps_count = 0;
          ps_phase = PH_MONTH;
        end else ps_phase = PH_FAIL;
      end
      PH_MONTH: begin
        if (dg && ps_count < 2) begin
          ps_acc.month = TwoW'(ps_acc.month * 10 + TwoW'(d));
          ps_count++;
        end else if (ps_count > 0 && c == (ps_slash ? CH_SLASH : CH_DASH)) begin
          ps_count = 0;
          ps_phase = PH_DAY;
        end else ps_phase = PH_FAIL;
      end
      PH_DAY: begin
        if (dg && ps_count < 2) begin
          ps_acc.day = TwoW'(ps_acc.day * 10 + TwoW'(d));
          ps_count++;
        end else if (ps_count == 0) ps_phase = PH_FAIL;
        else if (blank_char(c) || c == CH_T) begin
          ps_count = 0;
          ps_phase = PH_TLEAD;
        end else commit_fields(1'b0);
      end
      PH_HOUR: begin
        if (dg && ps_count < 2) begin
          ps_acc.hour = TwoW'(ps_acc.hour * 10 + TwoW'(d));
          ps_count++;
        end else if (ps_count > 0 && c == CH_COLON) begin
          ps_count = 0;
          ps_phase = PH_MIN;
        end else ps_phase = PH_FAIL;
      end
      PH_MIN: begin
        if (dg && ps_count < 2) begin
          ps_acc.minute = TwoW'(ps_acc.minute * 10 + TwoW'(d));
          ps_count++;
        end else if (ps_count == 0) ps_phase = PH_FAIL;
        else if (c == CH_COLON) begin
          ps_count = 0;
          ps_phase = PH_SEC;
        end else close_time(c);
      end
      PH_SEC: begin
        if (dg && ps_count < 2) begin
          ps_acc.second = TwoW'(ps_acc.second * 10 + TwoW'(d));
          ps_count++;
        end else if (ps_count == 0) ps_phase = PH_FAIL;
        else if (c == CH_DOT || c == CH_COMMA) begin
          ps_count = 0;
          ps_phase = PH_MS;
        end else close_time(c);
      end
      PH_MS: begin
        if (dg && ps_count < 3) begin
          ps_acc.milli = MilliW'(ps_acc.milli * 10 + MilliW'(d));
          ps_count++;
        end else if (ps_count == 0) ps_phase = PH_FAIL;
        else begin
          if (ps_count == 1) ps_acc.milli = MilliW'(ps_acc.milli * 100);
          else if (ps_count == 2) ps_acc.milli = MilliW'(ps_acc.milli * 10);
          close_time(c);
        end
      end
      PH_OK: ;
      default: ps_phase = PH_FAIL;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_parse();
      held = '0;
      expected_results.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, parse_ok",
                          int'(out_mon.parse_ok), 0);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (out_mon.parse_ok !== want.parse_ok)
            report_mismatch("parse_ok", int'(out_mon.parse_ok), int'(want.parse_ok));
          if (out_mon.year_value !== want.fields.year)
            report_mismatch("year", int'(out_mon.year_value), int'(want.fields.year));
          if (out_mon.month_value !== want.fields.month)
            report_mismatch("month", int'(out_mon.month_value), int'(want.fields.month));
          if (out_mon.day_value !== want.fields.day)
            report_mismatch("day", int'(out_mon.day_value), int'(want.fields.day));
          if (out_mon.hour_value !== want.fields.hour)
            report_mismatch("hour", int'(out_mon.hour_value), int'(want.fields.hour));
          if (out_mon.minute_value !== want.fields.minute)
            report_mismatch("minute", int'(out_mon.minute_value),
                            int'(want.fields.minute));
          if (out_mon.second_value !== want.fields.second)
            report_mismatch("second", int'(out_mon.second_value),
                            int'(want.fields.second));
          if (out_mon.milli_value !== want.fields.milli)
            report_mismatch("milli", int'(out_mon.milli_value), int'(want.fields.milli));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        parse_char(in_mon.char_code);
        if (in_mon.char_code == CH_NUL) begin
          want.parse_ok = (ps_phase == PH_OK);
          want.fields   = held;
          expected_results.push_back(want);
          clear_parse();
        end
      end
    end
    waiting = expected_results.size();
  end

endmodule

/* tb/tb_date_time_text_parser.sv */
`timescale 1ns / 1ps

module tb_date_time_text_parser;
  import dttp_pkg::*;

  localparam int CycleLimit = 400000;

  logic clk;
  logic rst_n;

  dttp_in_if  in_if ();
  dttp_out_if out_if ();

  int mismatches;
  int waiting;
  int checked;

  int gap_pct;
  int stall_pct;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int cycle_count;
  int chars_sent;
  int lines_sent;

  logic [CharW-1:0] line_q[$];

  date_time_text_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  dttp_result_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .mismatches (mismatches),
    .waiting    (waiting),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("date_time_text_parser verification failed");
      $finish;
    end
  end

  // hold off once for a long stretch when asked, else stall at random
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = 300;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_char(logic [CharW-1:0] c);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    do @(posedge clk); while (!in_if.ready);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
    send_char(CH_NUL);
    lines_sent++;
  endtask

  task automatic send_text(string text);
    line_q.delete();
    for (int i = 0; i < text.len(); i++) line_q.push_back(text[i]);
    send_line();
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
  endtask

  task automatic push_digits(int n);
    repeat (n) line_q.push_back(CH_ZERO + CharW'($urandom_range(9)));
  endtask

  task automatic push_blanks(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(5);
      line_q.push_back((r == 5) ? CH_SPACE : CH_TAB + CharW'(r));
    end
  endtask

  function automatic int field_len(int hi);
    if ($urandom_range(99) < 4) return $urandom_range(1) * (hi + 1);
    return $urandom_range(1, hi);
  endfunction

  task automatic build_line();
    bit slash;
    int r;
    line_q.delete();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(8)) line_q.push_back(CharW'($urandom_range(1, 255)));
      return;
    end
    push_blanks($urandom_range(2));
    push_digits(($urandom_range(99) < 3) ? 5 : $urandom_range(4));
    slash = 1'($urandom_range(1));
    line_q.push_back(slash ? CH_SLASH : CH_DASH);
    push_digits(field_len(2));
    if ($urandom_range(99) < 4) slash = ~slash;
    line_q.push_back(slash ? CH_SLASH : CH_DASH);
    push_digits(field_len(2));
    if ($urandom_range(99) < 60) begin
      if ($urandom_range(1)) line_q.push_back(CH_T);
      else push_blanks(1);
      push_blanks($urandom_range(2));
      push_digits(field_len(2));
      line_q.push_back(($urandom_range(99) < 4) ? CH_DOT : CH_COLON);
      push_digits(field_len(2));
      if ($urandom_range(99) < 60) begin
        line_q.push_back(CH_COLON);
        push_digits(field_len(2));
        if ($urandom_range(99) < 60) begin
          line_q.push_back($urandom_range(1) ? CH_DOT : CH_COMMA);
          push_digits(field_len(3));
        end
      end
      r = $urandom_range(3);
      if (r == 1) begin
        push_blanks(1);
        repeat ($urandom_range(3)) line_q.push_back(CharW'($urandom_range(1, 255)));
      end else if (r == 2) begin
        line_q.push_back(CharW'($urandom_range(33, 126)));
      end else if (r == 3) begin
        push_blanks($urandom_range(1, 2));
      end
    end else if ($urandom_range(1)) begin
      repeat ($urandom_range(1, 3)) line_q.push_back(CharW'($urandom_range(1, 255)));
    end
    if ($urandom_range(99) < 5 && line_q.size() > 0)
      line_q[$urandom_range(line_q.size() - 1)] = CharW'($urandom_range(1, 255));
  endtask

  task automatic run_phase(int gap, int stall, int n_chars);
    int start;
    gap_pct   = gap;
    stall_pct = stall;
    start     = chars_sent;
    while (chars_sent - start < n_chars) begin
      build_line();
      send_line();
    end
    drain();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.char_code = '0;
    out_if.ready    = 1'b0;
    gap_pct         = 0;
    stall_pct       = 0;
    hold_req        = 1'b0;
    hold_done       = 1'b0;
    hold_left       = 0;
    cycle_count     = 0;
    chars_sent      = 0;
    lines_sent      = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_text("");
    send_text("9999-99-99T99:99:59.999");
    send_text(" \t/1/2 x");
    send_text("12345-1-1");
    send_text("2024-1/5");
    send_text("1-2-345");
    send_text("1-2-3 \t 4:5");
    send_text("1-2-3T4:5:6,7");
    send_text("0-0-0T0:0:0.25 z");
    send_text("1-2-3T4:5x");
    send_text("1-2-3T123:4");
    line_q.delete();
    line_q.push_back(8'hFF);
    line_q.push_back(8'h80);
    send_line();
    drain();

    run_phase(0, 0, 320);
    run_phase(61, 0, 320);
    run_phase(0, 61, 320);
    run_phase(33, 33, 320);
    hold_req = 1'b1;
    run_phase(0, 0, 110);

    repeat (10) @(posedge clk);
    $display("sent %0d strings, %0d characters; %0d results checked", lines_sent,
             chars_sent, checked);
    $display("phases: no idling, sender gaps, receiver stalls, both, long receiver hold");
    if (mismatches == 0 && waiting == 0) begin
      $display("date_time_text_parser verification clean");
    end else begin
      $display("date_time_text_parser verification failed");
    end
    $finish;
  end

endmodule
